FILE: sv/mooring_line_node_force_unit_defines.svh
// Assertion macros for the mooring line node force unit.
// Used by the top level; expects clk and rst in scope.
`ifndef MOORING_LINE_NODE_FORCE_UNIT_DEFINES_SVH
`define MOORING_LINE_NODE_FORCE_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define MLNF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlnf assertion failed");

// Antecedent implies consequent in the next cycle.
`define MLNF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlnf assertion failed");

`endif

FILE: sv/mlnf_pkg.sv
// Shared types, register indexes and saturation helper for the mooring line node force unit.
// No dependencies.
`default_nettype none
package mlnf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_SEG_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIAL_K    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIAL_C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEABED_Z   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEABED_K   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEABED_C   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_SCL  = 3'd7;

  localparam logic [46:0] P47 = {47{1'b1}};

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_t;

  typedef struct packed {
    logic        [30:0] seg_len;
    logic        [46:0] ea;
    logic        [46:0] ca;
    logic signed [47:0] weight;
    logic signed [31:0] seabed_z;
    logic        [46:0] seabed_k;
    logic        [46:0] seabed_c;
    logic        [23:0] fscale;
  } cfg_t;

  function automatic logic signed [47:0] sat48(input logic neg, input logic [127:0] mag);
    logic signed [47:0] r;
    if (!neg) begin
      r = (mag > 128'(P47)) ? $signed({1'b0, P47}) : $signed(mag[47:0]);
    end else begin
      r = (mag > (128'(P47) + 128'd1)) ? $signed({1'b1, 47'd0})
                                        : $signed(48'(~mag[47:0] + 48'd1));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/mooring_line_node_force_unit.sv
// Mooring line node force unit: per-node axial, weight and seabed force of a lumped-mass line.
// Depends on mlnf_pkg, mlnf_cfg, mlnf_arith and mooring_line_node_force_unit_defines.svh.
//
// Nodes enter in chain order; each dynamic node's scaled force leaves when the next node
// arrives (a dynamic last node's force follows at once). One node is worked at a time and
// in_stall stays high until it is done. All products, quotients and the segment length go
// through one shared bit-serial unit, one operation after another. A node that closes a
// segment needs three squares, three dot products, a square root, a divide and a multiply
// (plus a multiply and a divide when the segment is stretched) and three multiply-divide
// pairs; each force result adds two seabed multiplies when in contact and three scale
// multiplies.
`default_nettype none
`include "mooring_line_node_force_unit_defines.svh"
module mooring_line_node_force_unit
  import mlnf_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic signed [31:0]     pos_x,
  input  wire logic signed [31:0]     pos_y,
  input  wire logic signed [31:0]     pos_z,
  input  wire logic signed [31:0]     vel_x,
  input  wire logic signed [31:0]     vel_y,
  input  wire logic signed [31:0]     vel_z,
  input  wire logic                   node_dynamic,
  input  wire logic                   first_node,
  input  wire logic                   last_node,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [47:0]          force_x,
  output logic signed [47:0]          force_y,
  output logic signed [47:0]          force_z,
  output logic [9:0]                  node_index,
  output logic                        last_result
);

  localparam int CNT_W = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam logic [CNT_W:0] NODES_LIM = (CNT_W+1)'(MAX_NODES);

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_CHK, S_SQ, S_DOT, S_SQRT, S_EL_MUL, S_EL_DIV, S_VAX, S_DAMP,
    S_TOT, S_CMUL, S_CDIV, S_NODE_SEL, S_SB, S_SB_K, S_SB_C, S_SCALE, S_EMIT, S_FIN
  } state_t;

  cfg_t cfg;

  mlnf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic         ar_start, ar_busy, ar_done;
  arith_op_t    ar_op;
  logic [127:0] ar_opa, ar_res;
  logic [63:0]  ar_opb;

  mlnf_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (ar_start),
    .op    (ar_op),
    .opa   (ar_opa),
    .opb   (ar_opb),
    .busy  (ar_busy),
    .done  (ar_done),
    .res   (ar_res)
  );

  state_t st;
  logic   issued;
  logic   [1:0] k;
  logic   pass2;

  logic signed [31:0] cur_p [3];
  logic signed [31:0] cur_v [3];
  logic               cur_dyn, cur_last, do_seg;

  logic signed [31:0] prev_p [3];
  logic signed [31:0] prev_v [3];
  logic signed [47:0] left_f [3];
  logic               prev_dyn, prev_valid, prev_has_left;
  logic [CNT_W-1:0]   node_counter;

  logic signed [32:0] dx [3];
  logic signed [32:0] dv [3];
  logic [67:0]        acc_n;
  logic signed [68:0] acc_dot;
  logic [34:0]        len_l;
  logic [127:0]       prod_r;
  logic [46:0]        el;
  logic               vax_neg;
  logic [63:0]        vax_mag;
  logic signed [47:0] damp;
  logic signed [47:0] stot;
  logic signed [47:0] seg_f [3];

  logic signed [51:0] nt_tot [3];
  logic signed [31:0] nt_z, nt_vz;
  logic [CNT_W-1:0]   nt_idx;
  logic               nt_last;
  logic [79:0]        kp;
  logic signed [47:0] sc [3];

  // Combinational helpers
  logic [30:0]        seg_len;
  logic [32:0]        dxk_mag, dvk_mag;
  logic               dxk_neg, dvk_neg;
  logic [47:0]        stot_mag;
  logic [67:0]        dot_mag;
  logic signed [32:0] pen;
  logic [31:0]        vz_mag;
  logic [51:0]        ntk_mag;
  logic [CNT_W-1:0]   idx_next;
  logic [CNT_W:0]     cnt_inc;
  logic signed [48:0] w_half;
  logic               op_state;
  logic signed [49:0] tot_sum;
  logic signed [82:0] sb_num;
  logic [66:0]        sb_shift;
  logic [46:0]        sb_push;
  logic [CNT_W+9:0]   idx_wide;

  always_comb begin
    seg_len  = (cfg.seg_len == 31'd0) ? 31'd1 : cfg.seg_len;
    dxk_neg  = dx[k][32];
    dvk_neg  = dv[k][32];
    dxk_mag  = dxk_neg ? 33'(-dx[k]) : 33'(dx[k]);
    dvk_mag  = dvk_neg ? 33'(-dv[k]) : 33'(dv[k]);
    stot_mag = stot[47] ? 48'(-stot) : 48'(stot);
    dot_mag  = acc_dot[68] ? 68'(-acc_dot) : 68'(acc_dot);
    pen      = 33'(cfg.seabed_z) - 33'(nt_z);
    vz_mag   = nt_vz[31] ? 32'(-nt_vz) : 32'(nt_vz);
    ntk_mag  = nt_tot[k][51] ? 52'(-nt_tot[k]) : 52'(nt_tot[k]);
    cnt_inc  = (CNT_W+1)'(node_counter) + (CNT_W+1)'(1);
    idx_next = (cnt_inc < NODES_LIM) ? cnt_inc[CNT_W-1:0] : NODES_LIM[CNT_W-1:0] - 1'b1;
    w_half   = (49'(cfg.weight) + $signed({48'd0, cfg.weight[47]})) >>> 1;
    tot_sum  = $signed({3'b000, el}) + 50'sd65536 + 50'(damp);
    sb_num   = $signed({3'b000, kp}) +
               (nt_vz[31] ? $signed({3'b000, ar_res[79:0]}) : -$signed({3'b000, ar_res[79:0]}));
    sb_shift = 67'(sb_num >>> 16);
    sb_push  = (sb_num <= 83'sd0) ? 47'd0 : ((sb_shift > 67'(P47)) ? P47 : sb_shift[46:0]);
    idx_wide = (CNT_W+10)'(nt_idx);
  end

  always_comb begin
    op_state = (st == S_SQ) || (st == S_DOT) || (st == S_SQRT) || (st == S_EL_MUL) ||
               (st == S_EL_DIV) || (st == S_VAX) || (st == S_DAMP) || (st == S_CMUL) ||
               (st == S_CDIV) || (st == S_SB_K) || (st == S_SB_C) || (st == S_SCALE);
    ar_start = op_state && !issued;
    ar_op    = OP_MUL;
    ar_opa   = '0;
    ar_opb   = '0;
    unique case (st)
      S_SQ:     begin ar_opa = 128'(dxk_mag); ar_opb = 64'(dxk_mag); end
      S_DOT:    begin ar_opa = 128'(dvk_mag); ar_opb = 64'(dxk_mag); end
      S_SQRT:   begin ar_op = OP_SQRT; ar_opa = 128'(acc_n); end
      S_EL_MUL: begin ar_opa = 128'(len_l - 35'(seg_len)); ar_opb = 64'(cfg.ea); end
      S_EL_DIV: begin ar_op = OP_DIV; ar_opa = prod_r; ar_opb = 64'(seg_len); end
      S_VAX:    begin ar_op = OP_DIV; ar_opa = 128'(dot_mag); ar_opb = 64'(len_l); end
      S_DAMP:   begin ar_opa = 128'(vax_mag); ar_opb = 64'(cfg.ca); end
      S_CMUL:   begin ar_opa = 128'(dxk_mag); ar_opb = 64'(stot_mag); end
      S_CDIV:   begin ar_op = OP_DIV; ar_opa = prod_r; ar_opb = 64'(len_l); end
      S_SB_K:   begin ar_opa = 128'(pen); ar_opb = 64'(cfg.seabed_k); end
      S_SB_C:   begin ar_opa = 128'(vz_mag); ar_opb = 64'(cfg.seabed_c); end
      S_SCALE:  begin ar_opa = 128'(ntk_mag); ar_opb = 64'(cfg.fscale); end
      default:  begin ar_op = OP_MUL; end
    endcase
  end

  assign in_stall = (st != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      issued        <= 1'b0;
      k             <= '0;
      pass2         <= 1'b0;
      prev_valid    <= 1'b0;
      prev_has_left <= 1'b0;
      prev_dyn      <= 1'b0;
      node_counter  <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_p[i] <= '0;
        prev_v[i] <= '0;
        left_f[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && (st != S_EMIT)) out_valid <= 1'b0;
      if (ar_start) issued <= 1'b1;
      if (ar_done) issued <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            cur_p[0] <= pos_x; cur_p[1] <= pos_y; cur_p[2] <= pos_z;
            cur_v[0] <= vel_x; cur_v[1] <= vel_y; cur_v[2] <= vel_z;
            cur_dyn  <= node_dynamic;
            cur_last <= last_node;
            do_seg   <= prev_valid && !first_node;
            pass2    <= 1'b0;
            st       <= S_DIFF;
          end
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            dx[i] <= 33'(cur_p[i]) - 33'(prev_p[i]);
            dv[i] <= 33'(cur_v[i]) - 33'(prev_v[i]);
          end
          st <= S_CHK;
        end
        S_CHK: begin
          for (int i = 0; i < 3; i++) seg_f[i] <= '0;
          acc_n   <= '0;
          acc_dot <= '0;
          k       <= '0;
          if (!do_seg || (dx[0] == 33'sd0 && dx[1] == 33'sd0 && dx[2] == 33'sd0)) begin
            st <= S_NODE_SEL;
          end else begin
            st <= S_SQ;
          end
        end
        S_SQ: if (ar_done) begin
          acc_n <= acc_n + ar_res[67:0];
          st    <= S_DOT;
        end
        S_DOT: if (ar_done) begin
          if (dxk_neg ^ dvk_neg) acc_dot <= acc_dot - $signed({3'b000, ar_res[65:0]});
          else                   acc_dot <= acc_dot + $signed({3'b000, ar_res[65:0]});
          if (k == 2'd2) begin
            k  <= '0;
            st <= S_SQRT;
          end else begin
            k  <= k + 2'd1;
            st <= S_SQ;
          end
        end
        S_SQRT: if (ar_done) begin
          len_l <= ar_res[34:0];
          el    <= '0;
          st    <= (ar_res[34:0] > 35'(seg_len)) ? S_EL_MUL : S_VAX;
        end
        S_EL_MUL: if (ar_done) begin
          prod_r <= ar_res;
          st     <= S_EL_DIV;
        end
        S_EL_DIV: if (ar_done) begin
          el <= (ar_res > 128'(P47)) ? P47 : ar_res[46:0];
          st <= S_VAX;
        end
        S_VAX: if (ar_done) begin
          vax_neg <= acc_dot[68];
          if (acc_dot[68]) begin
            vax_mag <= (ar_res > {64'd0, 1'b1, 63'd0}) ? {1'b1, 63'd0} : ar_res[63:0];
          end else begin
            vax_mag <= (ar_res > {65'd0, {63{1'b1}}}) ? {1'b0, {63{1'b1}}} : ar_res[63:0];
          end
          st <= S_DAMP;
        end
        S_DAMP: if (ar_done) begin
          damp <= sat48(vax_neg, ar_res >> 16);
          st   <= S_TOT;
        end
        S_TOT: begin
          if (tot_sum > $signed(50'(P47)))        stot <= $signed({1'b0, P47});
          else if (tot_sum < -50'sh800000000000)  stot <= $signed({1'b1, 47'd0});
          else                                    stot <= tot_sum[47:0];
          k  <= '0;
          st <= S_CMUL;
        end
        S_CMUL: if (ar_done) begin
          prod_r <= ar_res;
          st     <= S_CDIV;
        end
        S_CDIV: if (ar_done) begin
          seg_f[k] <= sat48(dxk_neg ^ stot[47], ar_res);
          if (k == 2'd2) begin
            k  <= '0;
            st <= S_NODE_SEL;
          end else begin
            k  <= k + 2'd1;
            st <= S_CMUL;
          end
        end
        S_NODE_SEL: begin
          k <= '0;
          if (!pass2) begin
            if (do_seg && prev_dyn) begin
              for (int i = 0; i < 2; i++) begin
                nt_tot[i] <= (prev_has_left ? 52'(left_f[i]) : 52'sd0) - 52'(seg_f[i]);
              end
              if (prev_has_left) nt_tot[2] <= 52'(left_f[2]) - 52'(seg_f[2]) - 52'(cfg.weight);
              else               nt_tot[2] <= -52'(seg_f[2]) - 52'(w_half);
              nt_z    <= prev_p[2];
              nt_vz   <= prev_v[2];
              nt_idx  <= node_counter;
              nt_last <= cur_last && !cur_dyn;
              st      <= S_SB;
            end else begin
              pass2 <= 1'b1;
            end
          end else begin
            if (cur_last && cur_dyn) begin
              for (int i = 0; i < 2; i++) begin
                nt_tot[i] <= do_seg ? 52'(seg_f[i]) : 52'sd0;
              end
              nt_tot[2] <= do_seg ? 52'(seg_f[2]) - 52'(w_half) : 52'sd0;
              nt_z    <= cur_p[2];
              nt_vz   <= cur_v[2];
              nt_idx  <= do_seg ? idx_next : '0;
              nt_last <= 1'b1;
              st      <= S_SB;
            end else begin
              st <= S_FIN;
            end
          end
        end
        S_SB: begin
          st <= (pen > 33'sd0) ? S_SB_K : S_SCALE;
        end
        S_SB_K: if (ar_done) begin
          kp <= ar_res[79:0];
          st <= S_SB_C;
        end
        S_SB_C: if (ar_done) begin
          nt_tot[2] <= nt_tot[2] + 52'(sb_push);
          st        <= S_SCALE;
        end
        S_SCALE: if (ar_done) begin
          sc[k] <= sat48(nt_tot[k][51], ar_res >> 16);
          if (k == 2'd2) begin
            k  <= '0;
            st <= S_EMIT;
          end else begin
            k <= k + 2'd1;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            force_x     <= sc[0];
            force_y     <= sc[1];
            force_z     <= sc[2];
            node_index  <= idx_wide[9:0];
            last_result <= nt_last;
            if (pass2) begin
              st <= S_FIN;
            end else begin
              pass2 <= 1'b1;
              st    <= S_NODE_SEL;
            end
          end
        end
        S_FIN: begin
          if (cur_last) begin
            prev_valid    <= 1'b0;
            prev_has_left <= 1'b0;
            node_counter  <= '0;
          end else begin
            for (int i = 0; i < 3; i++) begin
              prev_p[i] <= cur_p[i];
              prev_v[i] <= cur_v[i];
              left_f[i] <= seg_f[i];
            end
            prev_dyn      <= cur_dyn;
            prev_valid    <= 1'b1;
            prev_has_left <= do_seg;
            node_counter  <= do_seg ? idx_next : '0;
          end
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `MLNF_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
  `MLNF_ASSERT_SAME(a_start_idle, ar_start, !ar_busy)
  `MLNF_ASSERT_NEXT(a_emit_loads, (st == S_EMIT) && (!out_valid || !out_stall), out_valid)
  `MLNF_ASSERT_SAME(a_idle_unit_quiet, st == S_IDLE, !ar_busy && !issued)

endmodule
`default_nettype wire

FILE: sv/mlnf_cfg.sv
// Configuration register file for the mooring line node force unit.
// Depends on mlnf_pkg.
`default_nettype none
module mlnf_cfg
  import mlnf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seg_len  <= 31'd65536;
      cfg.ea       <= 47'd65536;
      cfg.ca       <= '0;
      cfg.weight   <= '0;
      cfg.seabed_z <= -32'sd20971520;
      cfg.seabed_k <= 47'd655360000;
      cfg.seabed_c <= '0;
      cfg.fscale   <= 24'd65536;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEG_LEN:   cfg.seg_len  <= cfg_data[30:0];
        REG_AXIAL_K:   cfg.ea       <= cfg_data[46:0];
        REG_AXIAL_C:   cfg.ca       <= cfg_data[46:0];
        REG_WEIGHT:    cfg.weight   <= $signed(cfg_data[47:0]);
        REG_SEABED_Z:  cfg.seabed_z <= $signed(cfg_data[31:0]);
        REG_SEABED_K:  cfg.seabed_k <= cfg_data[46:0];
        REG_SEABED_C:  cfg.seabed_c <= cfg_data[46:0];
        REG_FORCE_SCL: cfg.fscale   <= cfg_data[23:0];
        default:       cfg.fscale   <= cfg.fscale;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/mlnf_arith.sv
// Shared bit-serial unit: unsigned multiply, divide and square root on one adder.
// Depends on mlnf_pkg.
`default_nettype none
module mlnf_arith
  import mlnf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire arith_op_t    op,
  input  wire logic [127:0] opa,
  input  wire logic [63:0]  opb,
  output logic              busy,
  output logic              done,
  output logic [127:0]      res
);

  localparam logic [7:0] MUL_STEPS  = 8'd64;
  localparam logic [7:0] DIV_STEPS  = 8'd128;
  localparam logic [7:0] SQRT_STEPS = 8'd35;

  arith_op_t    op_r;
  logic [127:0] acc;
  logic [64:0]  rem;
  logic [34:0]  root;
  logic [63:0]  divr;
  logic [7:0]   cnt;

  logic [65:0]  x, y, sum;
  logic         sub;
  logic [64:0]  r2;

  always_comb begin
    r2  = '0;
    x   = '0;
    y   = '0;
    sub = 1'b0;
    unique case (op_r)
      OP_MUL: begin
        x = {1'b0, rem};
        y = acc[0] ? {2'b00, divr} : '0;
      end
      OP_DIV: begin
        r2  = {rem[63:0], acc[127]};
        x   = {1'b0, r2};
        y   = {2'b00, divr};
        sub = 1'b1;
      end
      OP_SQRT: begin
        r2  = {rem[62:0], acc[127:126]};
        x   = {1'b0, r2};
        y   = {29'd0, root, 2'b01};
        sub = 1'b1;
      end
      default: begin
        x = '0;
      end
    endcase
    sum = x + (sub ? ~y : y) + {65'd0, sub};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op_r <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        op_r <= op;
        divr <= opb;
        rem  <= '0;
        root <= '0;
        unique case (op)
          OP_MUL:  begin acc <= {64'd0, opa[63:0]}; cnt <= MUL_STEPS; end
          OP_DIV:  begin acc <= opa;                cnt <= DIV_STEPS; end
          OP_SQRT: begin acc <= opa << 58;          cnt <= SQRT_STEPS; end
          default: begin acc <= opa;                cnt <= MUL_STEPS; end
        endcase
      end else if (busy) begin
        unique case (op_r)
          OP_MUL: begin
            rem        <= {1'b0, sum[64:1]};
            acc[63:0]  <= {sum[0], acc[63:1]};
          end
          OP_DIV: begin
            rem <= sum[65] ? r2 : sum[64:0];
            acc <= {acc[126:0], ~sum[65]};
          end
          OP_SQRT: begin
            rem  <= sum[65] ? r2 : sum[64:0];
            root <= {root[33:0], ~sum[65]};
            acc  <= acc << 2;
          end
          default: begin
            rem <= rem;
          end
        endcase
        cnt <= cnt - 8'd1;
        if (cnt == 8'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    unique case (op_r)
      OP_MUL:  res = {rem[63:0], acc[63:0]};
      OP_DIV:  res = acc;
      OP_SQRT: res = {93'd0, root};
      default: res = acc;
    endcase
  end

endmodule
`default_nettype wire
